// ===== src/frt_pkg.sv =====
// Shared types and constants for the flow byte rate table.
// Holds the item codes, the controller states and the command and status bundles.
// No dependencies.
package frt_pkg;

  localparam int FRT_TABLE_DEPTH = 64;
  localparam int FRT_COUNT_WIDTH = 32;

  localparam int MODE_W   = 3;
  localparam int KEY_W    = 32;
  localparam int BYTES_W  = 16;
  localparam int DIR_W    = 2;
  localparam int STATUS_W = 2;
  localparam int RATE_W   = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_PACKET      = 3'd0,
    MODE_TICK        = 3'd1,
    MODE_QUERY       = 3'd2,
    MODE_SET_HIDDEN  = 3'd3,
    MODE_CLEAR_DIRTY = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT  = 2'd0,
    ST_NEW  = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } status_t;

  localparam logic [DIR_W-1:0] DIR_UP = 2'd0;
  localparam logic [DIR_W-1:0] DIR_RX = 2'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_READ,
    S_APPLY,
    S_SWEEP_RD,
    S_SWEEP_WR,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic idle;
    logic lookup_rd;
    logic apply;
    logic finish;
    logic sweep_rd;
    logic sweep_wr;
  } frt_cmd_t;

  typedef struct packed {
    logic              req_valid;
    logic [MODE_W-1:0] req_mode;
    logic              fill_zero;
    logic              sweep_last;
    logic              out_free;
  } frt_stat_t;

endpackage

// ===== src/frt_if.sv =====
// Valid/ready channel interfaces for the flow byte rate table.
// Depends on frt_pkg for the field widths.
interface frt_req_if import frt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [KEY_W-1:0]   flow_key;
  logic [BYTES_W-1:0] packet_bytes;
  logic [DIR_W-1:0]   direction;
  logic               hide_value;

  modport source (output valid, mode, flow_key, packet_bytes, direction, hide_value,
                  input ready);
  modport sink (input valid, mode, flow_key, packet_bytes, direction, hide_value,
                output ready);
endinterface

interface frt_rsp_if import frt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [RATE_W-1:0]   tx_rate;
  logic [RATE_W-1:0]   rx_rate;
  logic                is_hidden;
  logic                is_dirty;

  modport source (output valid, status, tx_rate, rx_rate, is_hidden, is_dirty,
                  input ready);
  modport sink (input valid, status, tx_rate, rx_rate, is_hidden, is_dirty,
                output ready);
endinterface

// ===== src/frt_ctrl.sv =====
// Controller state machine of the flow byte rate table.
// Sequences lookup, update and tick sweep; depends on frt_pkg.
module frt_ctrl import frt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  frt_stat_t stat,
  output frt_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (stat.req_valid) begin
          if (stat.req_mode == MODE_TICK) begin
            state_next = stat.fill_zero ? S_FINISH : S_SWEEP_RD;
          end else if (stat.req_mode inside {MODE_PACKET, MODE_QUERY, MODE_SET_HIDDEN,
                                             MODE_CLEAR_DIRTY}) begin
            state_next = S_LOOKUP;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_LOOKUP:   state_next = S_READ;
      S_READ:     state_next = S_APPLY;
      S_APPLY: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      S_SWEEP_RD: state_next = S_SWEEP_WR;
      S_SWEEP_WR: state_next = stat.sweep_last ? S_FINISH : S_SWEEP_RD;
      S_FINISH: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE:     cmd.idle = 1'b1;
      S_READ:     cmd.lookup_rd = 1'b1;
      S_APPLY:    cmd.apply = stat.out_free;
      S_SWEEP_RD: cmd.sweep_rd = 1'b1;
      S_SWEEP_WR: cmd.sweep_wr = 1'b1;
      S_FINISH:   cmd.finish = stat.out_free;
      default:    cmd = '0;
    endcase
  end

endmodule

// ===== src/frt_datapath.sv =====
// Datapath of the flow byte rate table: key registers, match vector, entry memory
// and result register. Depends on frt_pkg and the channel interfaces in frt_if.
module frt_datapath import frt_pkg::*; #(
  parameter int TABLE_DEPTH = FRT_TABLE_DEPTH,
  parameter int COUNT_WIDTH = FRT_COUNT_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  input  frt_cmd_t  cmd,
  output frt_stat_t stat,
  frt_req_if.sink   req,
  frt_rsp_if.source rsp
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic                   dirty;
    logic                   hidden;
    logic [COUNT_WIDTH-1:0] tx_acc;
    logic [COUNT_WIDTH-1:0] rx_acc;
    logic [COUNT_WIDTH-1:0] tx_prev;
    logic [COUNT_WIDTH-1:0] rx_prev;
  } entry_t;

  logic [MODE_W-1:0]      item_mode;
  logic [KEY_W-1:0]       item_key;
  logic [BYTES_W-1:0]     item_bytes;
  logic [DIR_W-1:0]       item_dir;
  logic                   item_hide;
  logic [KEY_W-1:0]       keys [TABLE_DEPTH];
  logic [FILL_W-1:0]      fill;
  logic [TABLE_DEPTH-1:0] match;
  logic [IDX_W-1:0]       enc_idx;
  logic                   hit;
  logic [IDX_W-1:0]       hit_idx;
  logic [IDX_W-1:0]       ptr;
  logic [IDX_W-1:0]       rd_addr;
  entry_t                 mem [TABLE_DEPTH];
  entry_t                 rd;
  entry_t                 upd;
  entry_t                 mem_wd;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_wa;
  logic [COUNT_WIDTH:0]   sum_tx;
  logic [COUNT_WIDTH:0]   sum_rx;
  logic                   accept;
  logic                   full;
  logic                   is_packet;
  logic                   app_new;
  logic                   out_free;

  assign req.ready = cmd.idle;
  assign accept    = req.valid && req.ready;
  assign full      = (fill == FILL_W'(TABLE_DEPTH));
  assign is_packet = (item_mode == MODE_PACKET);
  assign app_new   = cmd.apply && is_packet && !hit && !full;
  assign out_free  = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      item_mode  <= req.mode;
      item_key   <= req.flow_key;
      item_bytes <= req.packet_bytes;
      item_dir   <= req.direction;
      item_hide  <= req.hide_value;
    end
  end

  always_ff @(posedge clk) begin
    if (app_new) begin
      keys[fill[IDX_W-1:0]] <= item_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (app_new) begin
      fill <= fill + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= '0;
    end else begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        match[i] <= (FILL_W'(i) < fill) && (keys[i] == item_key);
      end
    end
  end

  // Keys are unique among live entries, so an OR of the matching indices is the index.
  always_comb begin
    enc_idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (match[i]) enc_idx = enc_idx | IDX_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup_rd) begin
      hit     <= |match;
      hit_idx <= enc_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idle) begin
      ptr <= '0;
    end else if (cmd.sweep_wr) begin
      ptr <= ptr + 1'b1;
    end
  end

  assign rd_addr = cmd.sweep_rd ? ptr : enc_idx;

  always_ff @(posedge clk) begin
    if (cmd.lookup_rd || cmd.sweep_rd) begin
      rd <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  assign sum_tx = {1'b0, rd.tx_acc} + (COUNT_WIDTH + 1)'(item_bytes);
  assign sum_rx = {1'b0, rd.rx_acc} + (COUNT_WIDTH + 1)'(item_bytes);

  always_comb begin
    upd = rd;
    case (item_mode)
      MODE_PACKET: begin
        if (item_dir == DIR_UP) begin
          upd.tx_acc = sum_tx[COUNT_WIDTH] ? COUNT_MAX : sum_tx[COUNT_WIDTH-1:0];
        end else if (item_dir == DIR_RX) begin
          upd.rx_acc = sum_rx[COUNT_WIDTH] ? COUNT_MAX : sum_rx[COUNT_WIDTH-1:0];
        end
        upd.dirty = 1'b1;
      end
      MODE_SET_HIDDEN:  upd.hidden = item_hide;
      MODE_CLEAR_DIRTY: upd.dirty = 1'b0;
      default:          upd = rd;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = hit_idx;
    mem_wd = upd;
    if (cmd.sweep_wr) begin
      mem_we         = 1'b1;
      mem_wa         = ptr;
      mem_wd         = rd;
      mem_wd.tx_prev = rd.tx_acc;
      mem_wd.rx_prev = rd.rx_acc;
      mem_wd.tx_acc  = '0;
      mem_wd.rx_acc  = '0;
    end else if (cmd.apply && hit) begin
      mem_we = 1'b1;
    end else if (app_new) begin
      mem_we = 1'b1;
      mem_wa = fill[IDX_W-1:0];
      mem_wd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.apply || cmd.finish) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply && hit) begin
      rsp.status    <= ST_HIT;
      rsp.tx_rate   <= RATE_W'(upd.tx_prev);
      rsp.rx_rate   <= RATE_W'(upd.rx_prev);
      rsp.is_hidden <= upd.hidden;
      rsp.is_dirty  <= upd.dirty;
    end else if (cmd.apply || cmd.finish) begin
      rsp.tx_rate   <= '0;
      rsp.rx_rate   <= '0;
      rsp.is_hidden <= 1'b0;
      rsp.is_dirty  <= 1'b0;
      if (cmd.finish) begin
        rsp.status <= ST_HIT;
      end else if (!is_packet) begin
        rsp.status <= ST_MISS;
      end else if (full) begin
        rsp.status <= ST_FULL;
      end else begin
        rsp.status <= ST_NEW;
      end
    end
  end

  assign stat.req_valid  = req.valid;
  assign stat.req_mode   = req.mode;
  assign stat.fill_zero  = (fill == '0);
  assign stat.sweep_last = (FILL_W'(ptr) == fill - 1'b1);
  assign stat.out_free   = out_free;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(TABLE_DEPTH))
    else $error("entry count exceeds the table depth");

  a_key_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match))
    else $error("flow key matches more than one entry");

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.apply || cmd.finish) |-> (!rsp.valid || rsp.ready))
    else $error("result written over a transaction still waiting");

  a_sweep_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.sweep_rd || cmd.sweep_wr) |-> (FILL_W'(ptr) < fill))
    else $error("tick sweep beyond the live entries");
`endif

endmodule

// ===== src/flow_byte_rate_table.sv =====
// Usage notes for the flow byte rate table.
// Items arrive on the req channel and results leave on the rsp channel; both are
// valid/ready channels, and a transaction takes place at a clock edge with valid and
// ready both high. Every item gives exactly one result.
// Packet, query, set hidden and clear dirty items pass through the accept cycle, a
// registered key compare against all live entries, an entry memory read, and the
// update with the result register load, which waits while a result is still held.
// The next item is taken in the cycle after the update. A tick sweeps the live
// entries, reading and then writing each one through the entry memory read and
// write ports; an empty table skips the sweep, and unused modes do no lookup.
// At reset the table is empty and no result is pending; there is no clearing pass.
// The result register lets the block accept the next item while a result waits; if
// the receiver stalls, that item is held before its update until the register frees.
// Depends on frt_pkg, frt_if, frt_ctrl and frt_datapath.
module flow_byte_rate_table import frt_pkg::*; #(
  parameter int TABLE_DEPTH = FRT_TABLE_DEPTH,
  parameter int COUNT_WIDTH = FRT_COUNT_WIDTH
) (
  input logic       clk,
  input logic       rst,
  frt_req_if.sink   req,
  frt_rsp_if.source rsp
);

  frt_cmd_t  cmd;
  frt_stat_t stat;

  frt_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  frt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat),
    .req  (req),
    .rsp  (rsp)
  );

endmodule
